// ===== rtl/core/rtpst_pkg.sv =====
`timescale 1ns / 1ps

package rtpst_pkg;

    localparam int TableEntriesDefault = 64;
    localparam int CountWidthDefault   = 32;
    localparam int PosMax              = 2047;
    localparam logic [15:0] ThresholdReset = 16'd50;

    localparam logic [15:0] EtherIpv4   = 16'h0800;
    localparam logic [7:0]  ProtoUdp    = 8'h11;
    localparam logic [7:0]  RtpVersion  = 8'h80;
    localparam logic [7:0]  RtcpSr      = 8'hc8;
    localparam logic [7:0]  RtcpRr      = 8'hc9;
    localparam logic [6:0]  PtCn        = 7'h0d;
    localparam logic [6:0]  PtRed       = 7'h61;
    localparam logic [6:0]  PtDtmf      = 7'h65;
    localparam logic [6:0]  PtDtmfAlt   = 7'h76;

    typedef enum logic [2:0] {
        ST_NOT_RTP    = 3'd0,
        ST_KNOWN      = 3'd1,
        ST_NEW        = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_READOUT    = 3'd4
    } t_status;

    typedef struct packed {
        logic        rtp;
        logic [31:0] ssrc;
        logic [6:0]  pt;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_frame;

    typedef struct packed {
        t_status     status;
        logic [5:0]  index;
        logic        valid;
        logic [31:0] count;
        logic        reportable;
        logic [31:0] ssrc;
        logic [6:0]  pt;
        logic [31:0] sip;
        logic [15:0] sport;
        logic [31:0] dip;
        logic [15:0] dport;
    } t_result;

endpackage

// ===== rtl/core/rtpst_parser.sv =====
`timescale 1ns / 1ps

// Byte position counter and header capture; classifies a frame on its final byte.
module rtpst_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output rtpst_pkg::t_frame    o_frame
);

    logic [10:0] r_pos, n_pos;
    logic [15:0] r_etype, n_etype;
    logic [3:0]  r_ihl, n_ihl;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_sip, n_sip;
    logic [31:0] r_dip, n_dip;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [7:0]  r_b0, n_b0;
    logic [7:0]  r_b1, n_b1;
    logic [31:0] r_ssrc, n_ssrc;

    logic [10:0] off;
    logic [11:0] rel;
    logic [11:0] length;

    always_comb begin
        n_etype = r_etype;
        n_ihl   = r_ihl;
        n_proto = r_proto;
        n_sip   = r_sip;
        n_dip   = r_dip;
        n_sport = r_sport;
        n_dport = r_dport;
        n_b0    = r_b0;
        n_b1    = r_b1;
        n_ssrc  = r_ssrc;
        case (r_pos)
            11'd12: n_etype[15:8] = i_data_byte;
            11'd13: n_etype[7:0]  = i_data_byte;
            11'd14: n_ihl         = i_data_byte[3:0];
            11'd23: n_proto       = i_data_byte;
            11'd26: n_sip[31:24]  = i_data_byte;
            11'd27: n_sip[23:16]  = i_data_byte;
            11'd28: n_sip[15:8]   = i_data_byte;
            11'd29: n_sip[7:0]    = i_data_byte;
            11'd30: n_dip[31:24]  = i_data_byte;
            11'd31: n_dip[23:16]  = i_data_byte;
            11'd32: n_dip[15:8]   = i_data_byte;
            11'd33: n_dip[7:0]    = i_data_byte;
            default: ;
        endcase
        // The RTP offset follows the IHL, which may arrive in this very byte.
        off = 11'({n_ihl, 2'b00}) + 11'd22;
        rel = 12'(r_pos) - 12'(off) + 12'd8;
        if (!rel[11]) begin
            case (rel)
                12'd0:  n_sport[15:8] = i_data_byte;
                12'd1:  n_sport[7:0]  = i_data_byte;
                12'd2:  n_dport[15:8] = i_data_byte;
                12'd3:  n_dport[7:0]  = i_data_byte;
                12'd8:  n_b0          = i_data_byte;
                12'd9:  n_b1          = i_data_byte;
                12'd16: n_ssrc[31:24] = i_data_byte;
                12'd17: n_ssrc[23:16] = i_data_byte;
                12'd18: n_ssrc[15:8]  = i_data_byte;
                12'd19: n_ssrc[7:0]   = i_data_byte;
                default: ;
            endcase
        end
        length = 12'(r_pos) + 12'd1;
        if (r_pos == 11'(rtpst_pkg::PosMax)) begin
            n_pos = r_pos;
        end else begin
            n_pos = r_pos + 11'd1;
        end
    end

    always_comb begin
        o_frame.rtp   = (length >= 12'(off) + 12'd12) &&
                        n_etype == rtpst_pkg::EtherIpv4 && n_proto == rtpst_pkg::ProtoUdp &&
                        n_b0 == rtpst_pkg::RtpVersion &&
                        n_b1 != rtpst_pkg::RtcpSr && n_b1 != rtpst_pkg::RtcpRr &&
                        n_b1[6:0] != rtpst_pkg::PtCn && n_b1[6:0] != rtpst_pkg::PtRed &&
                        n_b1[6:0] != rtpst_pkg::PtDtmf && n_b1[6:0] != rtpst_pkg::PtDtmfAlt;
        o_frame.ssrc  = n_ssrc;
        o_frame.pt    = n_b1[6:0];
        o_frame.sip   = n_sip;
        o_frame.dip   = n_dip;
        o_frame.sport = n_sport;
        o_frame.dport = n_dport;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_byte)) begin
            r_pos   <= '0;
            r_etype <= '0;
            r_ihl   <= '0;
            r_proto <= '0;
            r_sip   <= '0;
            r_dip   <= '0;
            r_sport <= '0;
            r_dport <= '0;
            r_b0    <= '0;
            r_b1    <= '0;
            r_ssrc  <= '0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_etype <= n_etype;
            r_ihl   <= n_ihl;
            r_proto <= n_proto;
            r_sip   <= n_sip;
            r_dip   <= n_dip;
            r_sport <= n_sport;
            r_dport <= n_dport;
            r_b0    <= n_b0;
            r_b1    <= n_b1;
            r_ssrc  <= n_ssrc;
        end
    end

endmodule

// ===== rtl/core/rtpst_table.sv =====
`timescale 1ns / 1ps

// Stream table: key memory and count/endpoint memory, linear search sequencer.
module rtpst_table #(
    parameter int TABLE_ENTRIES = rtpst_pkg::TableEntriesDefault,
    parameter int COUNT_WIDTH   = rtpst_pkg::CountWidthDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_frame_done,
    input  rtpst_pkg::t_frame    i_frame,
    input  logic                 i_read,
    input  logic [5:0]           i_read_index,
    input  logic [15:0]          i_threshold,
    output logic                 o_idle,
    output logic                 o_res_valid,
    output rtpst_pkg::t_result   o_res
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW = $clog2(TABLE_ENTRIES + 1);
    localparam int XW = (AW > 6) ? AW : 6;
    localparam int CW = (UW > XW) ? UW : XW;
    localparam int BW = COUNT_WIDTH + 96;
    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [38:0]   key_mem [TABLE_ENTRIES];
    logic [BW-1:0] ent_mem [TABLE_ENTRIES];
    logic [38:0]   r_kq;
    logic [BW-1:0] r_bq;

    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] rd_addr;
    logic [UW-1:0] r_used, n_used;
    logic [5:0]    r_ridx, n_ridx;
    rtpst_pkg::t_frame r_job, n_job;

    logic [XW-1:0] ridx_x;
    logic          key_we, ent_we;
    logic [AW-1:0] wr_addr;
    logic [BW-1:0] ent_wd;
    logic [COUNT_WIDTH-1:0] q_count, hit_count;
    logic          in_range, hit, last, read_ok;

    assign ridx_x   = XW'(i_read_index);
    assign q_count  = r_bq[BW-1 -: COUNT_WIDTH];
    assign in_range = CW'(r_cnt) < CW'(r_used);
    assign hit      = in_range && r_kq == {r_job.ssrc, r_job.pt};
    assign last     = CW'(r_cnt) + CW'(1) >= CW'(r_used);
    assign hit_count = (q_count == CountMax) ? q_count : q_count + COUNT_WIDTH'(1);
    assign read_ok  = CW'(r_ridx) < CW'(r_used);
    assign o_idle   = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_used      = r_used;
        n_ridx      = r_ridx;
        n_job       = r_job;
        rd_addr     = '0;
        key_we      = 1'b0;
        ent_we      = 1'b0;
        wr_addr     = r_used[AW-1:0];
        ent_wd      = {COUNT_WIDTH'(1), r_job.sip, r_job.dip, r_job.sport, r_job.dport};
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_read) begin
                    rd_addr = ridx_x[AW-1:0];
                    n_ridx  = i_read_index;
                    n_state = S_READ;
                end else if (i_frame_done) begin
                    if (i_frame.rtp) begin
                        n_job   = i_frame;
                        n_cnt   = '0;
                        n_state = S_SCAN;
                    end else begin
                        o_res_valid = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                rd_addr  = r_cnt + AW'(1);
                n_cnt    = r_cnt + AW'(1);
                o_res.ssrc  = r_job.ssrc;
                o_res.pt    = r_job.pt;
                o_res.sip   = r_job.sip;
                o_res.dip   = r_job.dip;
                o_res.sport = r_job.sport;
                o_res.dport = r_job.dport;
                if (hit) begin
                    ent_we  = 1'b1;
                    wr_addr = r_cnt;
                    ent_wd  = {hit_count, r_bq[95:0]};
                    o_res_valid  = 1'b1;
                    o_res.status = rtpst_pkg::ST_KNOWN;
                    o_res.index  = 6'(r_cnt);
                    o_res.valid  = 1'b1;
                    o_res.count  = 32'(hit_count);
                    o_res.reportable = 32'(hit_count) >= 32'(i_threshold);
                    o_res.sip   = r_bq[95:64];
                    o_res.dip   = r_bq[63:32];
                    o_res.sport = r_bq[31:16];
                    o_res.dport = r_bq[15:0];
                    n_state = S_IDLE;
                end else if (last) begin
                    o_res_valid = 1'b1;
                    if (CW'(r_used) < CW'(TABLE_ENTRIES)) begin
                        key_we = 1'b1;
                        ent_we = 1'b1;
                        n_used = r_used + UW'(1);
                        o_res.status = rtpst_pkg::ST_NEW;
                        o_res.index  = 6'(r_used);
                        o_res.valid  = 1'b1;
                        o_res.count  = 32'd1;
                        o_res.reportable = 32'd1 >= 32'(i_threshold);
                    end else begin
                        o_res.status = rtpst_pkg::ST_TABLE_FULL;
                    end
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_res_valid  = 1'b1;
                o_res.status = rtpst_pkg::ST_READOUT;
                o_res.index  = r_ridx;
                if (read_ok) begin
                    o_res.valid = 1'b1;
                    o_res.count = 32'(q_count);
                    o_res.reportable = 32'(q_count) >= 32'(i_threshold);
                    o_res.ssrc  = r_kq[38:7];
                    o_res.pt    = r_kq[6:0];
                    o_res.sip   = r_bq[95:64];
                    o_res.dip   = r_bq[63:32];
                    o_res.sport = r_bq[31:16];
                    o_res.dport = r_bq[15:0];
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
        r_cnt  <= n_cnt;
        r_ridx <= n_ridx;
        r_job  <= n_job;
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[wr_addr] <= {r_job.ssrc, r_job.pt};
        end
        r_kq <= key_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[wr_addr] <= ent_wd;
        end
        r_bq <= ent_mem[rd_addr];
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_used) <= CW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |-> (r_used == $past(r_used) + UW'(1) && $past(key_we)))
        else $error("entry count moved without an insert");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_read && i_frame_done && i_frame.rtp) |=> (r_state == S_SCAN))
        else $error("rtp frame did not start a search");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (o_res_valid && o_res.status == rtpst_pkg::ST_READOUT))
        else $error("readout did not complete");

endmodule

// ===== rtl/core/rtp_stream_tracker.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                     Payload
// input     i_in_valid / o_in_stall       i_action, i_data_byte, i_last_byte, i_read_index
// output    o_out_valid / i_out_stall     o_status ... o_dest_port
// config    i_cfg_we                      i_cfg_wdata (report threshold)
//
// Frame bytes that are not the last of a frame are taken one per cycle while the table is idle.
// A final byte of an RTP frame starts a linear search of the key memory, one entry per cycle,
// that ends early on a hit; a readout fetches one entry. Both share the single memory read port.
// Reset is synchronous and empties the table at once through its fill count. Every transfer
// stalls during a search or readout; final bytes and reads also while a result waits.
module rtp_stream_tracker #(
    parameter int TABLE_ENTRIES = rtpst_pkg::TableEntriesDefault,
    parameter int COUNT_WIDTH   = rtpst_pkg::CountWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [5:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_entry_index,
    output logic        o_entry_valid,
    output logic [31:0] o_packet_count,
    output logic        o_reportable,
    output logic [31:0] o_ssrc,
    output logic [6:0]  o_payload_type,
    output logic [31:0] o_source_ip,
    output logic [15:0] o_source_port,
    output logic [31:0] o_dest_ip,
    output logic [15:0] o_dest_port,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic [15:0]        r_threshold;
    logic               r_out_valid;
    rtpst_pkg::t_result r_out;
    rtpst_pkg::t_frame  frame;
    rtpst_pkg::t_result res;
    logic               res_valid;
    logic               table_idle;
    logic               take;
    logic               byte_take;

    // A transfer that needs the output register waits until it is free.
    assign o_in_stall = !table_idle || (r_out_valid && (i_action || i_last_byte));
    assign take       = i_in_valid && !o_in_stall;
    assign byte_take  = take && !i_action;

    rtpst_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (byte_take),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_frame     (frame)
    );

    rtpst_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame_done (byte_take && i_last_byte),
        .i_frame      (frame),
        .i_read       (take && i_action),
        .i_read_index (i_read_index),
        .i_threshold  (r_threshold),
        .o_idle       (table_idle),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= rtpst_pkg::ThresholdReset;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_entry_index  = r_out.index;
    assign o_entry_valid  = r_out.valid;
    assign o_packet_count = r_out.count;
    assign o_reportable   = r_out.reportable;
    assign o_ssrc         = r_out.ssrc;
    assign o_payload_type = r_out.pt;
    assign o_source_ip    = r_out.sip;
    assign o_source_port  = r_out.sport;
    assign o_dest_ip      = r_out.dip;
    assign o_dest_port    = r_out.dport;

endmodule

// ===== bench/rtpst_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the stream tracker, keeps its own copy of the
// stream table and flags every result that differs from the prediction.
module rtpst_checker
    import rtpst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [5:0]  i_read_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [5:0]  i_entry_index,
    input  logic        i_entry_valid,
    input  logic [31:0] i_packet_count,
    input  logic        i_reportable,
    input  logic [31:0] i_ssrc,
    input  logic [6:0]  i_payload_type,
    input  logic [31:0] i_source_ip,
    input  logic [15:0] i_source_port,
    input  logic [31:0] i_dest_ip,
    input  logic [15:0] i_dest_port,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_full_seen
);

    localparam int Entries = 64;

    logic [15:0] threshold;
    logic [10:0] position;
    logic [63:0] hdr [4];
    logic [38:0] key_mem [Entries];
    logic [31:0] sip_mem [Entries];
    logic [31:0] dip_mem [Entries];
    logic [15:0] sport_mem [Entries];
    logic [15:0] dport_mem [Entries];
    logic [31:0] count_mem [Entries];
    logic        valid_mem [Entries];
    int          used;
    t_result     pending_results [$];

    assign o_pending = pending_results.size();

    function automatic t_result entry_result(t_status st, int idx);
        t_result r;
        r            = '0;
        r.status     = st;
        r.index      = idx[5:0];
        r.valid      = 1'b1;
        r.count      = count_mem[idx];
        r.reportable = count_mem[idx] >= {16'd0, threshold};
        r.ssrc       = key_mem[idx][38:7];
        r.pt         = key_mem[idx][6:0];
        r.sip        = sip_mem[idx];
        r.sport      = sport_mem[idx];
        r.dip        = dip_mem[idx];
        r.dport      = dport_mem[idx];
        return r;
    endfunction

    // Header capture: fixed offsets first, then the ones that follow the IHL.
    task automatic capture_byte(int p, logic [7:0] b);
        int ihl;
        int off;
        if (p == 12) hdr[0][15:8] = b;
        if (p == 13) hdr[0][7:0] = b;
        if (p == 14) hdr[0][23:16] = {4'd0, b[3:0]};
        if (p == 23) hdr[0][31:24] = b;
        if (p >= 26 && p <= 29) hdr[1][(24 - 8 * (p - 26)) +: 8] = b;
        if (p >= 30 && p <= 33) hdr[1][(56 - 8 * (p - 30)) +: 8] = b;
        if (p >= 14) begin
            ihl = (p == 14) ? int'(b[3:0]) : int'(hdr[0][19:16]);
            off = ihl * 4 + 22;
            if (p == off - 8) hdr[2][15:8] = b;
            if (p == off - 7) hdr[2][7:0] = b;
            if (p == off - 6) hdr[2][31:24] = b;
            if (p == off - 5) hdr[2][23:16] = b;
            if (p == off) hdr[2][39:32] = b;
            if (p == off + 1) hdr[2][47:40] = b;
            if (p >= off + 8 && p <= off + 11) hdr[3][(24 - 8 * (p - off - 8)) +: 8] = b;
        end
    endtask

    task automatic classify_frame(int len);
        int          off;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [6:0]  pt;
        logic [31:0] ssrc;
        logic [38:0] key;
        logic        is_rtp;
        t_result     r;
        int          hit;
        off    = int'(hdr[0][19:16]) * 4 + 22;
        b0     = hdr[2][39:32];
        b1     = hdr[2][47:40];
        pt     = b1[6:0];
        ssrc   = hdr[3][31:0];
        key    = {ssrc, pt};
        is_rtp = len >= off + 12 && hdr[0][15:0] == EtherIpv4 && hdr[0][31:24] == ProtoUdp
                 && b0 == RtpVersion && b1 != RtcpSr && b1 != RtcpRr && pt != PtCn
                 && pt != PtRed && pt != PtDtmf && pt != PtDtmfAlt;
        r   = '0;
        hit = -1;
        if (is_rtp) begin
            for (int i = 0; i < Entries; i++) begin
                if (hit < 0 && valid_mem[i] && key_mem[i] == key) hit = i;
            end
            if (hit >= 0) begin
                if (count_mem[hit] != 32'hFFFF_FFFF) count_mem[hit] = count_mem[hit] + 1;
                r = entry_result(ST_KNOWN, hit);
            end else if (used < Entries) begin
                valid_mem[used] = 1'b1;
                key_mem[used]   = key;
                count_mem[used] = 32'd1;
                sip_mem[used]   = hdr[1][31:0];
                dip_mem[used]   = hdr[1][63:32];
                sport_mem[used] = hdr[2][15:0];
                dport_mem[used] = hdr[2][31:16];
                r = entry_result(ST_NEW, used);
                used++;
            end else begin
                r.status = ST_TABLE_FULL;
                r.ssrc   = ssrc;
                r.pt     = pt;
                r.sip    = hdr[1][31:0];
                r.sport  = hdr[2][15:0];
                r.dip    = hdr[1][63:32];
                r.dport  = hdr[2][31:16];
            end
        end
        pending_results.push_back(r);
    endtask

    task automatic track_item(logic act, logic [7:0] b, logic lst, logic [5:0] ridx);
        t_result r;
        if (act) begin
            if (valid_mem[ridx]) begin
                r = entry_result(ST_READOUT, ridx);
            end else begin
                r        = '0;
                r.status = ST_READOUT;
                r.index  = ridx;
            end
            pending_results.push_back(r);
        end else begin
            capture_byte(int'(position), b);
            if (!lst) begin
                if (position != 11'(PosMax)) position = position + 1;
            end else begin
                classify_frame(int'(position) + 1);
                position = '0;
                for (int w = 0; w < 4; w++) hdr[w] = '0;
            end
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            o_errors++;
        end
    endfunction

    initial begin
        o_errors    = 0;
        o_results   = 0;
        o_full_seen = 0;
    end

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            threshold = ThresholdReset;
            position  = '0;
            used      = 0;
            for (int w = 0; w < 4; w++) hdr[w] = '0;
            for (int i = 0; i < Entries; i++) valid_mem[i] = 1'b0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (pending_results.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    o_errors++;
                end else begin
                    e = pending_results.pop_front();
                    if (e.status == ST_TABLE_FULL) o_full_seen++;
                    check_field("status", 32'(e.status), 32'(i_status));
                    check_field("entry_index", 32'(e.index), 32'(i_entry_index));
                    check_field("entry_valid", 32'(e.valid), 32'(i_entry_valid));
                    check_field("packet_count", e.count, i_packet_count);
                    check_field("reportable", 32'(e.reportable), 32'(i_reportable));
                    check_field("ssrc", e.ssrc, i_ssrc);
                    check_field("payload_type", 32'(e.pt), 32'(i_payload_type));
                    check_field("source_ip", e.sip, i_source_ip);
                    check_field("source_port", 32'(e.sport), 32'(i_source_port));
                    check_field("dest_ip", e.dip, i_dest_ip);
                    check_field("dest_port", 32'(e.dport), 32'(i_dest_port));
                end
            end
            if (i_cfg_we) threshold = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                track_item(i_action, i_data_byte, i_last_byte, i_read_index);
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the RTP stream tracker. Frames are built byte by
// byte, mostly well-formed RTP drawn from a small pool of streams so that
// known streams recur, with broken and noise frames mixed in. The checker
// beside the block does all prediction and comparison.
module testbench;
    import rtpst_pkg::*;

    localparam int CycleLimit = 2_000_000;
    localparam int PoolSize   = 8;
    localparam int SettleWait = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_action = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic [5:0]  i_read_index = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [5:0]  o_entry_index;
    logic        o_entry_valid;
    logic [31:0] o_packet_count;
    logic        o_reportable;
    logic [31:0] o_ssrc;
    logic [6:0]  o_payload_type;
    logic [31:0] o_source_ip;
    logic [15:0] o_source_port;
    logic [31:0] o_dest_ip;
    logic [15:0] o_dest_port;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    int errors;
    int pending;
    int results;
    int full_seen;

    // Sender and receiver coordination: quiet turns idling off for the last
    // stretch, hold_go asks the receiver for its one long hold-off.
    bit quiet = 1'b0;
    bit hold_go = 1'b0;
    bit hold_taken = 1'b0;

    int          cycles = 0;
    int          frames_sent = 0;
    int          reads_sent = 0;
    int          bytes_sent = 0;
    logic [31:0] ssrc_pool [PoolSize];
    logic [6:0]  pt_pool [PoolSize];

    rtp_stream_tracker dut (.*);

    rtpst_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_in_stall(o_in_stall),
        .i_action, .i_data_byte, .i_last_byte, .i_read_index,
        .i_out_valid(o_out_valid),
        .i_out_stall,
        .i_status(o_status), .i_entry_index(o_entry_index),
        .i_entry_valid(o_entry_valid), .i_packet_count(o_packet_count),
        .i_reportable(o_reportable), .i_ssrc(o_ssrc),
        .i_payload_type(o_payload_type), .i_source_ip(o_source_ip),
        .i_source_port(o_source_port), .i_dest_ip(o_dest_ip),
        .i_dest_port(o_dest_port),
        .i_cfg_we, .i_cfg_wdata,
        .o_errors(errors), .o_pending(pending),
        .o_results(results), .o_full_seen(full_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request so that
    // the block backs up and stalls its input while bytes keep coming.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // One transfer on the input channel. Stall is sampled on the falling edge,
    // where it is settled for the coming rising edge.
    task automatic offer(logic act, logic [7:0] b, logic lst, logic [5:0] ridx);
        bit taken;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_data_byte  <= b;
        i_last_byte  <= lst;
        i_read_index <= ridx;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        if (act) reads_sent++;
        else bytes_sent++;
    endtask

    task automatic read_entry(logic [5:0] idx);
        offer(1'b1, 8'($urandom), 1'($urandom), idx);
    endtask

    // Sends a whole frame; now and then a table read slips in between bytes,
    // which must leave the frame in progress untouched.
    task automatic send_frame(logic [7:0] frm [$]);
        for (int k = 0; k < frm.size(); k++) begin
            if ($urandom_range(0, 24) == 0) read_entry(6'($urandom));
            offer(1'b0, frm[k], k == frm.size() - 1, 6'($urandom));
        end
        frames_sent++;
        i_in_valid <= 1'b0;
    endtask

    // Kinds: 0 good RTP, 1 wrong ethertype, 2 wrong protocol, 3 wrong version
    // byte, 4 RTCP, 5 comfort noise/RED/DTMF payload type, 6 too short, 7 noise.
    task automatic build_frame(output logic [7:0] frm [$], input int kind,
                               input logic [31:0] ssrc, input logic [6:0] pt,
                               input int ihl, input int len);
        int          off;
        logic [6:0]  specials [4];
        specials = '{PtCn, PtRed, PtDtmf, PtDtmfAlt};
        off = ihl * 4 + 22;
        frm.delete();
        for (int k = 0; k < len; k++) frm.push_back(8'($urandom));
        if (kind == 7) return;
        if (len > 13) begin
            frm[12] = EtherIpv4[15:8];
            frm[13] = EtherIpv4[7:0];
        end
        if (kind == 1 && len > 13) frm[13] = 8'h06;
        if (len > 14) frm[14] = {4'($urandom), 4'(ihl)};
        if (len > 23) frm[23] = (kind == 2) ? 8'h06 : ProtoUdp;
        if (len > off + 1) begin
            frm[off]     = (kind == 3) ? 8'h40 : RtpVersion;
            frm[off + 1] = {1'($urandom), pt};
            if (kind == 4) frm[off + 1] = $urandom_range(0, 1) ? RtcpSr : RtcpRr;
            if (kind == 5) frm[off + 1] = {1'($urandom), specials[$urandom_range(0, 3)]};
        end
        for (int k = 0; k < 4; k++)
            if (len > off + 8 + k) frm[off + 8 + k] = ssrc[(24 - 8 * k) +: 8];
    endtask

    task automatic random_frame();
        logic [7:0] frm [$];
        int         kind;
        int         ihl;
        int         len;
        int         sel;
        logic [31:0] ssrc;
        logic [6:0]  pt;
        kind = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 7);
        ihl  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 5;
        sel  = $urandom_range(0, PoolSize - 1);
        ssrc = ssrc_pool[sel];
        pt   = pt_pool[sel];
        if ($urandom_range(0, 9) == 0) ssrc = $urandom;
        len = ihl * 4 + 34 + $urandom_range(0, 4);
        if (kind == 6) len = $urandom_range(1, ihl * 4 + 33);
        if (kind == 7) len = $urandom_range(1, 80);
        build_frame(frm, kind, ssrc, pt, ihl, len);
        send_frame(frm);
    endtask

    // Holds the sender back until every predicted result has come out, then
    // lets the block finish any search that produces nothing further.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SettleWait) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [7:0]  frm [$];
        logic [15:0] phase_thr [6];
        int          per_phase;
        for (int i = 0; i < PoolSize; i++) begin
            ssrc_pool[i] = $urandom;
            pt_pool[i]   = 7'($urandom);
            if (pt_pool[i] inside {PtCn, PtRed, PtDtmf, PtDtmfAlt}) pt_pool[i] = 7'd0;
        end
        ssrc_pool[0] = 32'h0;
        pt_pool[0]   = 7'd0;
        ssrc_pool[1] = 32'hFFFF_FFFF;
        pt_pool[1]   = 7'd127;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_threshold(16'd2);

        // Directed part: empty table reads, extreme keys, a repeat hit,
        // each reject reason, shortest frames at IHL 0 and reads at both ends.
        read_entry(6'd0);
        read_entry(6'd63);
        build_frame(frm, 0, 32'h0, 7'd0, 5, 54);
        send_frame(frm);
        build_frame(frm, 0, 32'hFFFF_FFFF, 7'd127, 15, 94);
        send_frame(frm);
        build_frame(frm, 0, 32'hFFFF_FFFF, 7'd127, 15, 95);
        send_frame(frm);
        for (int kind = 1; kind <= 7; kind++) begin
            build_frame(frm, kind, ssrc_pool[2], pt_pool[2], 5, (kind == 6) ? 53 : 60);
            send_frame(frm);
        end
        build_frame(frm, 0, 32'h0, 7'd0, 0, 34);
        send_frame(frm);
        build_frame(frm, 0, 32'h0, 7'd0, 0, 33);
        send_frame(frm);
        read_entry(6'd0);
        read_entry(6'd1);
        read_entry(6'd63);
        drain();

        // Random part in phases, each under its own threshold, extremes included.
        phase_thr = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'($urandom_range(0, 6)), 16'd50};
        per_phase = 3;
        for (int ph = 0; ph < 6; ph++) begin
            set_threshold(phase_thr[ph]);
            if (ph == 5) quiet = 1'b1;
            for (int f = 0; f < per_phase; f++) begin
                if (ph == 1 && f == 1) hold_go = 1'b1;
                if ($urandom_range(0, 5) == 0) read_entry(6'($urandom));
                random_frame();
            end
            if (ph == 5) begin
                for (int i = 0; i < 64; i++) read_entry(6'(i));
            end
            drain();
        end

        $display("Covered %0d frames (%0d bytes) and %0d table reads; %0d results checked,",
                 frames_sent, bytes_sent, reads_sent, results);
        $display("%0d of them with the stream table full.", full_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
